// ===== src/dct_pkg.sv =====
// ----------------------------------------------------------------------------
// dct_pkg: shared types and constants of the dual capture tachometer
// Widths of the fixed fields, reset values and the per-channel control struct.
// ----------------------------------------------------------------------------
package dct_pkg;

   // fixed field widths
   localparam int CAPTURE_BITS = 16;
   localparam int WRAP_BITS    = 16;
   localparam int NUM_BITS     = 27;
   localparam int RPM_BITS     = 28;

   // saturation point of a wrap count
   localparam logic [WRAP_BITS-1:0] WRAP_MAX = {WRAP_BITS{1'b1}};

   // speed numerator after reset
   localparam logic [NUM_BITS-1:0] NUM_RESET = 27'd93750000;

   // default width of the free-running counter
   localparam int COUNTER_BITS_DEFAULT = 16;

   // entries of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;

   // per-channel control that rides along with a measured delta
   typedef struct packed {
      logic captured;
      logic forward;
      logic positive;
   } lane_ctl_type;

   localparam int CTL_BITS = $bits(lane_ctl_type);

endpackage

// ===== src/dct_queue.sv =====
// ----------------------------------------------------------------------------
// dct_queue: small register FIFO
// Decouples the front from the back; head entry is read combinationally.
// ----------------------------------------------------------------------------
module dct_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     entry_ff [DEPTH];
   logic [ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/dct_front.sv =====
// ----------------------------------------------------------------------------
// dct_front: event intake of the dual capture tachometer
// Counts wraps, forms each channel's signed tick delta and queues the work.
// ----------------------------------------------------------------------------
module dct_front #(
   parameter int COUNTER_BITS = dct_pkg::COUNTER_BITS_DEFAULT,
   parameter int DIV_BITS     = dct_pkg::WRAP_BITS + COUNTER_BITS + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_wrap_seen,
   input  logic                              req_left_captured,
   input  logic [dct_pkg::CAPTURE_BITS-1:0]  req_left_capture,
   input  logic                              req_left_forward,
   input  logic                              req_right_captured,
   input  logic [dct_pkg::CAPTURE_BITS-1:0]  req_right_capture,
   input  logic                              req_right_forward,
   // queue side
   output logic                              q_push,
   input  logic                              q_full,
   output dct_pkg::lane_ctl_type             left_ctl,
   output logic [DIV_BITS-1:0]               left_delta,
   output dct_pkg::lane_ctl_type             right_ctl,
   output logic [DIV_BITS-1:0]               right_delta
);
   import dct_pkg::*;

   localparam int DW = DIV_BITS + 1;

   logic [WRAP_BITS-1:0]    left_wraps_ff, left_wraps_in;
   logic [WRAP_BITS-1:0]    right_wraps_ff, right_wraps_in;
   logic [CAPTURE_BITS-1:0] left_last_ff, left_last_in;
   logic [CAPTURE_BITS-1:0] right_last_ff, right_last_in;
   logic [WRAP_BITS-1:0]    left_wraps_eff, right_wraps_eff;
   logic [DW-1:0]           left_diff, right_diff;
   logic                    accept;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;
   assign q_push   = accept;

   // wrap counts including this event's wrap, saturating
   always_comb begin
      left_wraps_eff  = left_wraps_ff;
      right_wraps_eff = right_wraps_ff;
      if (req_wrap_seen) begin
         if (left_wraps_ff != WRAP_MAX) left_wraps_eff = left_wraps_ff + 1'b1;
         if (right_wraps_ff != WRAP_MAX) right_wraps_eff = right_wraps_ff + 1'b1;
      end
   end

   // delta = wraps * 2^COUNTER_BITS + value - last, two's complement
   assign left_diff = {2'b00, left_wraps_eff, {COUNTER_BITS{1'b0}}}
                    + DW'(req_left_capture) - DW'(left_last_ff);
   assign right_diff = {2'b00, right_wraps_eff, {COUNTER_BITS{1'b0}}}
                     + DW'(req_right_capture) - DW'(right_last_ff);

   // work item for the back
   always_comb begin
      left_ctl.captured  = req_left_captured;
      left_ctl.forward   = req_left_forward;
      left_ctl.positive  = ~left_diff[DW-1] & (|left_diff[DW-2:0]);
      left_delta         = left_diff[DW-2:0];
      right_ctl.captured = req_right_captured;
      right_ctl.forward  = req_right_forward;
      right_ctl.positive = ~right_diff[DW-1] & (|right_diff[DW-2:0]);
      right_delta        = right_diff[DW-2:0];
   end

   // channel state update on a transfer
   always_comb begin
      left_wraps_in  = left_wraps_ff;
      right_wraps_in = right_wraps_ff;
      left_last_in   = left_last_ff;
      right_last_in  = right_last_ff;
      if (accept) begin
         left_wraps_in  = req_left_captured ? '0 : left_wraps_eff;
         right_wraps_in = req_right_captured ? '0 : right_wraps_eff;
         if (req_left_captured) left_last_in = req_left_capture;
         if (req_right_captured) right_last_in = req_right_capture;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_wraps_ff  <= '0;
         right_wraps_ff <= '0;
         left_last_ff   <= '0;
         right_last_ff  <= '0;
      end else begin
         left_wraps_ff  <= left_wraps_in;
         right_wraps_ff <= right_wraps_in;
         left_last_ff   <= left_last_in;
         right_last_ff  <= right_last_in;
      end
   end

endmodule

// ===== src/dct_divider.sv =====
// ----------------------------------------------------------------------------
// dct_divider: restoring divider, one quotient bit per cycle
// Divides the speed numerator by a tick delta.
// ----------------------------------------------------------------------------
module dct_divider #(
   parameter int DIV_BITS = 33
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dct_pkg::NUM_BITS-1:0]  dividend,
   input  logic [DIV_BITS-1:0]           divisor,
   output logic                          busy,
   output logic [dct_pkg::NUM_BITS-1:0]  quotient
);
   import dct_pkg::*;

   localparam int CMP_BITS = ((DIV_BITS > NUM_BITS + 1) ? DIV_BITS : NUM_BITS + 1) + 1;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0] div_ff, div_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [NUM_BITS:0]   trial;
   logic [CMP_BITS-1:0] diff;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // one trial subtraction; the extra top bit of diff is the borrow
   assign trial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign diff  = CMP_BITS'(trial) - CMP_BITS'(div_ff);

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[CMP_BITS-1]) begin
            rem_in = diff[NUM_BITS-1:0];
         end else begin
            rem_in = trial[NUM_BITS-1:0];
         end
         quo_in  = {quo_ff[NUM_BITS-2:0], ~diff[CMP_BITS-1]};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

endmodule

// ===== src/dct_back.sv =====
// ----------------------------------------------------------------------------
// dct_back: speed computation of the dual capture tachometer
// Takes queued work, divides both channels at once, holds and reports speeds.
// ----------------------------------------------------------------------------
module dct_back #(
   parameter int DIV_BITS = 33
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_write,
   input  logic [dct_pkg::NUM_BITS-1:0]         csr_wdata,
   // queue side
   input  logic                                 q_empty,
   output logic                                 q_pop,
   input  dct_pkg::lane_ctl_type                left_ctl,
   input  logic [DIV_BITS-1:0]                  left_delta,
   input  dct_pkg::lane_ctl_type                right_ctl,
   input  logic [DIV_BITS-1:0]                  right_delta,
   // result channel
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [dct_pkg::RPM_BITS-1:0]  rsp_left_rpm,
   output logic signed [dct_pkg::RPM_BITS-1:0]  rsp_right_rpm
);
   import dct_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_DIVIDE  = 2'd1;
   localparam logic [1:0] ST_DELIVER = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   lane_ctl_type        left_ctl_ff, left_ctl_in;
   lane_ctl_type        right_ctl_ff, right_ctl_in;
   logic [RPM_BITS-1:0] left_held_ff, left_held_in;
   logic [RPM_BITS-1:0] right_held_ff, right_held_in;
   logic [RPM_BITS-1:0] left_out_ff, left_out_in;
   logic [RPM_BITS-1:0] right_out_ff, right_out_in;
   logic                out_valid_ff, out_valid_in;
   logic                div_start;
   logic                left_busy, right_busy;
   logic [NUM_BITS-1:0] left_quo, right_quo;
   logic [RPM_BITS-1:0] left_speed, right_speed;
   logic                out_free;

   assign rsp_empty     = ~out_valid_ff;
   assign rsp_left_rpm  = $signed(left_out_ff);
   assign rsp_right_rpm = $signed(right_out_ff);
   assign out_free      = ~out_valid_ff | rsp_pop;

   // both lanes share timing, so one start and a joint busy
   dct_divider #(.DIV_BITS(DIV_BITS)) u_left_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (left_delta),
      .busy     (left_busy),
      .quotient (left_quo)
   );

   dct_divider #(.DIV_BITS(DIV_BITS)) u_right_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (right_delta),
      .busy     (right_busy),
      .quotient (right_quo)
   );

   // signed speed: zero for a delta that is not positive, negated in reverse
   always_comb begin
      left_speed = '0;
      if (left_ctl_ff.positive) begin
         left_speed = left_ctl_ff.forward ? {1'b0, left_quo} : -{1'b0, left_quo};
      end
      right_speed = '0;
      if (right_ctl_ff.positive) begin
         right_speed = right_ctl_ff.forward ? {1'b0, right_quo} : -{1'b0, right_quo};
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      left_ctl_in   = left_ctl_ff;
      right_ctl_in  = right_ctl_ff;
      left_held_in  = left_held_ff;
      right_held_in = right_held_ff;
      left_out_in   = left_out_ff;
      right_out_in  = right_out_ff;
      out_valid_in  = out_valid_ff & ~rsp_pop;
      div_start     = 1'b0;
      q_pop         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop        = 1'b1;
               div_start    = 1'b1;
               left_ctl_in  = left_ctl;
               right_ctl_in = right_ctl;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!left_busy && !right_busy) begin
               if (left_ctl_ff.captured) left_held_in = left_speed;
               if (right_ctl_ff.captured) right_held_in = right_speed;
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               left_out_in  = left_held_ff;
               right_out_in = right_held_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // speed numerator register
   assign num_in = csr_write ? csr_wdata : num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_ff        <= NUM_RESET;
         left_held_ff  <= '0;
         right_held_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_ff        <= num_in;
         left_held_ff  <= left_held_in;
         right_held_ff <= right_held_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      left_ctl_ff  <= left_ctl_in;
      right_ctl_ff <= right_ctl_in;
      left_out_ff  <= left_out_in;
      right_out_ff <= right_out_in;
   end

endmodule

// ===== src/dual_capture_tachometer.sv =====
// ----------------------------------------------------------------------------
// dual_capture_tachometer: two-channel period tachometer
// Events queue at intake; the back pops one when idle, divides it in the 27-step
// shared-timing dividers and delivers it before it takes the next one.
// Up to four events queue between intake and divide; the output register holds one.
// Reset (synchronous): wrap counts, last captures and held speeds clear to zero,
// the speed numerator returns to 93750000, the queue and the output register empty.
// ----------------------------------------------------------------------------
module dual_capture_tachometer #(
   parameter int COUNTER_BITS = dct_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_wrap_seen,
   input  logic                                 req_left_captured,
   input  logic [dct_pkg::CAPTURE_BITS-1:0]     req_left_capture,
   input  logic                                 req_left_forward,
   input  logic                                 req_right_captured,
   input  logic [dct_pkg::CAPTURE_BITS-1:0]     req_right_capture,
   input  logic                                 req_right_forward,
   // result channel
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [dct_pkg::RPM_BITS-1:0]  rsp_left_rpm,
   output logic signed [dct_pkg::RPM_BITS-1:0]  rsp_right_rpm,
   // configuration
   input  logic                                 csr_write,
   input  logic [dct_pkg::NUM_BITS-1:0]         csr_wdata
);
   import dct_pkg::*;

   localparam int DIV_BITS   = WRAP_BITS + COUNTER_BITS + 1;
   localparam int ITEM_BITS  = 2 * (CTL_BITS + DIV_BITS);

   logic                q_push, q_full, q_pop, q_empty;
   lane_ctl_type        f_left_ctl, f_right_ctl, b_left_ctl, b_right_ctl;
   logic [DIV_BITS-1:0] f_left_delta, f_right_delta, b_left_delta, b_right_delta;
   logic [ITEM_BITS-1:0] q_wdata, q_rdata;

   dct_front #(
      .COUNTER_BITS (COUNTER_BITS),
      .DIV_BITS     (DIV_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_wrap_seen      (req_wrap_seen),
      .req_left_captured  (req_left_captured),
      .req_left_capture   (req_left_capture),
      .req_left_forward   (req_left_forward),
      .req_right_captured (req_right_captured),
      .req_right_capture  (req_right_capture),
      .req_right_forward  (req_right_forward),
      .q_push             (q_push),
      .q_full             (q_full),
      .left_ctl           (f_left_ctl),
      .left_delta         (f_left_delta),
      .right_ctl          (f_right_ctl),
      .right_delta        (f_right_delta)
   );

   // queue entry packing
   assign q_wdata = {f_left_ctl, f_left_delta, f_right_ctl, f_right_delta};
   assign {b_left_ctl, b_left_delta, b_right_ctl, b_right_delta} = q_rdata;

   dct_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_rdata),
      .empty     (q_empty)
   );

   dct_back #(
      .DIV_BITS (DIV_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_wdata     (csr_wdata),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .left_ctl      (b_left_ctl),
      .left_delta    (b_left_delta),
      .right_ctl     (b_right_ctl),
      .right_delta   (b_right_delta),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_left_rpm  (rsp_left_rpm),
      .rsp_right_rpm (rsp_right_rpm)
   );

endmodule
